// ----- rtl/itrt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itrt_pkg
// Shared types, constants and helpers for the signed integer to radix text
// converter.
// ----------------------------------------------------------------------------
package itrt_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 32;

  localparam int unsigned RADIX_W = 5;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned DIGIT_W = 4;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

  localparam logic [CHAR_W-1:0] CHAR_MINUS      = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO       = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_ALPHA_BASE = 8'h57;  // 'a' minus ten
  localparam logic [CHAR_W-1:0] CHAR_NONE       = 8'h00;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_DIG,
    ST_SIGN,
    ST_EMIT,
    ST_ERR
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic div_step;
    logic push;
    logic emit_sign;
    logic emit_pop;
    logic emit_err;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic radix_bad;
    logic div_done;
    logic quot_zero;
    logic neg;
    logic stack_one;
    logic out_free;
  } sts_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] ext;
    ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
    if (d < 4'd10) begin
      return CHAR_ZERO + ext;
    end else begin
      return CHAR_ALPHA_BASE + ext;
    end
  endfunction

endpackage

// ----- rtl/signed_int_to_radix_text_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_radix_text_core
// Converts a signed integer to ASCII text in radix 2 to 16, one character
// per output request, sign first, most significant digit first.
// ----------------------------------------------------------------------------
//  channel  | ports                                  | moves
//  ---------+----------------------------------------+---------------------
//  input    | in_valid, in_ready, in_value           | one integer
//  output   | out_valid, out_ready, out_character,   | one character
//           | out_last, out_error                    |
//  config   | cfg_wr_en, cfg_wr_data                 | radix, no wait
//
//  Per request: accept, then per digit a division in the bit-serial
//  divider and a push, then one output per character; a bad radix gives
//  an error result. The divider yields one quotient bit per cycle.
//  Reset: synchronous, active low; radix returns to ten, output empties.
//  Output stalls hold the sequencer; the next request is taken while the
//  final character still waits in the output register.
// ----------------------------------------------------------------------------
module signed_int_to_radix_text_core #(
  parameter int unsigned VALUE_WIDTH = itrt_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [itrt_pkg::RADIX_W-1:0]  cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [VALUE_WIDTH-1:0] in_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [itrt_pkg::CHAR_W-1:0]   out_character,
  output logic                          out_last,
  output logic                          out_error
);

  itrt_pkg::cmd_t cmd;
  itrt_pkg::sts_t sts;

  itrt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  itrt_dp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_value      (in_value),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_character (out_character),
    .out_last      (out_last),
    .out_error     (out_error)
  );

  // an error result is always a lone, empty, final character
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_last && (out_character == itrt_pkg::CHAR_NONE))
    else $error("error result without last or with a character");

  // the sign never closes a text
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last && !out_error |-> out_character != itrt_pkg::CHAR_MINUS)
    else $error("minus sign marked as final character");

  // a taken request closes the input straight after it is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input reopened straight after a request");

  // only one datapath command at a time
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.div_step, cmd.push, cmd.emit_sign, cmd.emit_pop,
              cmd.emit_err}))
    else $error("conflicting datapath commands");

endmodule

// ----- rtl/itrt_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itrt_ctrl
// Sequencer: takes a request, runs one bit-serial division per digit, then
// emits any sign and the stacked digits most significant first, or an error.
// ----------------------------------------------------------------------------
module itrt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  itrt_pkg::sts_t sts,
  output itrt_pkg::cmd_t cmd
);

  itrt_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= itrt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      itrt_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = sts.radix_bad ? itrt_pkg::ST_ERR : itrt_pkg::ST_DIV;
        end
      end
      itrt_pkg::ST_DIV: begin
        if (sts.div_done) begin
          state_nxt = itrt_pkg::ST_DIG;
        end
      end
      itrt_pkg::ST_DIG: begin
        if (!sts.quot_zero) begin
          state_nxt = itrt_pkg::ST_DIV;
        end else if (sts.neg) begin
          state_nxt = itrt_pkg::ST_SIGN;
        end else begin
          state_nxt = itrt_pkg::ST_EMIT;
        end
      end
      itrt_pkg::ST_SIGN: begin
        if (sts.out_free) begin
          state_nxt = itrt_pkg::ST_EMIT;
        end
      end
      itrt_pkg::ST_EMIT: begin
        if (sts.out_free && sts.stack_one) begin
          state_nxt = itrt_pkg::ST_IDLE;
        end
      end
      itrt_pkg::ST_ERR: begin
        if (sts.out_free) begin
          state_nxt = itrt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = itrt_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      itrt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      itrt_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      itrt_pkg::ST_DIG: begin
        cmd.push = 1'b1;
      end
      itrt_pkg::ST_SIGN: begin
        cmd.emit_sign = sts.out_free;
      end
      itrt_pkg::ST_EMIT: begin
        cmd.emit_pop = sts.out_free;
      end
      itrt_pkg::ST_ERR: begin
        cmd.emit_err = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ----- rtl/itrt_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itrt_dp
// Datapath: radix register, magnitude, restoring divider by the radix one
// quotient bit per cycle, digit stack and output register.
// ----------------------------------------------------------------------------
module itrt_dp #(
  parameter int unsigned VALUE_WIDTH = itrt_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [itrt_pkg::RADIX_W-1:0]         cfg_wr_data,
  input  logic signed [VALUE_WIDTH-1:0]        in_value,
  input  itrt_pkg::cmd_t                       cmd,
  output itrt_pkg::sts_t                       sts,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [itrt_pkg::CHAR_W-1:0]          out_character,
  output logic                                 out_last,
  output logic                                 out_error
);

  localparam int unsigned CNT_W  = $clog2(VALUE_WIDTH);
  localparam int unsigned DCNT_W = $clog2(VALUE_WIDTH + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_WIDTH - 1);
  localparam int unsigned DW = itrt_pkg::DIGIT_W;

  logic [itrt_pkg::RADIX_W-1:0] radix_r;
  logic                         neg_r;
  logic [VALUE_WIDTH-1:0]       mag_r, mag_nxt;
  logic [DW-1:0]                rem_r, rem_nxt;
  logic [CNT_W-1:0]             bit_cnt_r, bit_cnt_nxt;
  logic [VALUE_WIDTH-1:0][DW-1:0] stk_r, stk_nxt;
  logic [DCNT_W-1:0]            dcnt_r, dcnt_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [itrt_pkg::CHAR_W-1:0]  out_char_r, out_char_nxt;
  logic                         out_last_r, out_last_nxt;
  logic                         out_error_r, out_error_nxt;

  logic [DW:0]                  trial;
  logic [DW:0]                  trial_sub;
  logic                         ge;
  logic                         emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= itrt_pkg::RADIX_RESET;
    end else if (cfg_wr_en) begin
      radix_r <= cfg_wr_data;
    end
  end

  // one restoring division step
  assign trial     = {rem_r, mag_r[VALUE_WIDTH-1]};
  assign trial_sub = trial - radix_r;
  assign ge        = (trial >= radix_r);

  assign emit = cmd.emit_sign | cmd.emit_pop | cmd.emit_err;

  always_comb begin
    mag_nxt     = mag_r;
    rem_nxt     = rem_r;
    bit_cnt_nxt = bit_cnt_r;
    stk_nxt     = stk_r;
    dcnt_nxt    = dcnt_r;
    if (cmd.load) begin
      mag_nxt     = in_value[VALUE_WIDTH-1] ? (~in_value + 1'b1) : in_value;
      rem_nxt     = '0;
      bit_cnt_nxt = '0;
      dcnt_nxt    = '0;
    end else if (cmd.div_step) begin
      mag_nxt     = {mag_r[VALUE_WIDTH-2:0], ge};
      rem_nxt     = ge ? trial_sub[DW-1:0] : trial[DW-1:0];
      bit_cnt_nxt = bit_cnt_r + 1'b1;
    end else if (cmd.push) begin
      stk_nxt     = {stk_r[VALUE_WIDTH-2:0], rem_r};
      dcnt_nxt    = dcnt_r + 1'b1;
      rem_nxt     = '0;
      bit_cnt_nxt = '0;
    end else if (cmd.emit_pop) begin
      stk_nxt     = {{DW{1'b0}}, stk_r[VALUE_WIDTH-1:1]};
      dcnt_nxt    = dcnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    mag_r     <= mag_nxt;
    rem_r     <= rem_nxt;
    bit_cnt_r <= bit_cnt_nxt;
    stk_r     <= stk_nxt;
    dcnt_r    <= dcnt_nxt;
    if (cmd.load) begin
      neg_r <= in_value[VALUE_WIDTH-1];
    end
  end

  // output register: hold until taken, reload only when free
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_error_nxt = out_error_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
    end
    if (cmd.emit_sign) begin
      out_char_nxt  = itrt_pkg::CHAR_MINUS;
      out_last_nxt  = 1'b0;
      out_error_nxt = 1'b0;
    end else if (cmd.emit_pop) begin
      out_char_nxt  = itrt_pkg::digit_char(stk_r[0]);
      out_last_nxt  = (dcnt_r == DCNT_W'(1));
      out_error_nxt = 1'b0;
    end else if (cmd.emit_err) begin
      out_char_nxt  = itrt_pkg::CHAR_NONE;
      out_last_nxt  = 1'b1;
      out_error_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_char_r  <= out_char_nxt;
    out_last_r  <= out_last_nxt;
    out_error_r <= out_error_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;
  assign out_error     = out_error_r;

  assign sts.radix_bad = !(radix_r inside {[itrt_pkg::RADIX_MIN:itrt_pkg::RADIX_MAX]});
  assign sts.div_done  = (bit_cnt_r == CNT_LAST);
  assign sts.quot_zero = (mag_r == '0);
  assign sts.neg       = neg_r;
  assign sts.stack_one = (dcnt_r == DCNT_W'(1));
  assign sts.out_free  = !out_valid_r || out_ready;

endmodule
